// File: rtl/ps2_receive_demux_fifo_macros.svh
// Assertion macros for the PS/2 receive demux FIFO.
`ifndef PS2_RECEIVE_DEMUX_FIFO_MACROS_SVH
`define PS2_RECEIVE_DEMUX_FIFO_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define PS2RDF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ps2rdf assertion failed");
// Property that must hold in the cycle after the trigger.
`define PS2RDF_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("ps2rdf assertion failed");
`else
`define PS2RDF_ASSERT(label, clk, rst, prop)
`define PS2RDF_ASSERT_NEXT(label, clk, rst, trig, cons)
`endif
`endif

// File: rtl/ps2rdf_pkg.sv
// Shared types, codes and helpers for the PS/2 receive demux FIFO.
`default_nettype none
package ps2rdf_pkg;

  localparam int FIFO_DEPTH_DEF = 16;

  // Item commands
  localparam logic [1:0] CMD_RX     = 2'd0;
  localparam logic [1:0] CMD_ARM    = 2'd1;
  localparam logic [1:0] CMD_PULL   = 2'd2;
  localparam logic [1:0] CMD_CANCEL = 2'd3;

  // Device reply codes
  localparam logic [7:0] CODE_ACK    = 8'hFA;
  localparam logic [7:0] CODE_RESEND = 8'hFE;
  localparam logic [7:0] CODE_ECHO   = 8'hEE;

  // Datapath operations
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_REPLY  = 3'd1;
  localparam logic [2:0] OP_RESP   = 3'd2;
  localparam logic [2:0] OP_ARM    = 3'd3;
  localparam logic [2:0] OP_PULL   = 3'd4;
  localparam logic [2:0] OP_CANCEL = 3'd5;

  typedef struct packed {
    logic       load;
    logic [2:0] op;
  } ps2rdf_cmd_t;

  typedef struct packed {
    logic waiting;
    logic has_reply;
  } ps2rdf_status_t;

  function automatic logic is_reply_code(input logic [7:0] b);
    return (b == CODE_ACK) || (b == CODE_RESEND) || (b == CODE_ECHO);
  endfunction

endpackage
`default_nettype wire

// File: rtl/ps2rdf_if.sv
// Valid/ready channel interfaces for input items and results.
`default_nettype none
interface ps2rdf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic       expect_response;

  modport source (output valid, cmd, rx_byte, expect_response, input ready);
  modport sink (input valid, cmd, rx_byte, expect_response, output ready);
endinterface

interface ps2rdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pulled_byte;
  logic       pulled_valid;
  logic [7:0] reply_code;
  logic [7:0] response_byte;
  logic       busy_waiting;
  logic       fifo_empty;
  logic       fifo_full;

  modport source (output valid, pulled_byte, pulled_valid, reply_code, response_byte,
                  busy_waiting, fifo_empty, fifo_full, input ready);
  modport sink (input valid, pulled_byte, pulled_valid, reply_code, response_byte,
                busy_waiting, fifo_empty, fifo_full, output ready);
endinterface
`default_nettype wire

// File: rtl/ps2rdf_ctrl.sv
// Controller: handshake state and classification of each item into a datapath op.
`default_nettype none
module ps2rdf_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                cmd,
  input  wire logic [7:0]                rx_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  input  wire ps2rdf_pkg::ps2rdf_status_t status,
  output ps2rdf_pkg::ps2rdf_cmd_t        dp_cmd
);
  import ps2rdf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state;
  logic state_next;

  // Result register frees up in the same cycle it is taken.
  assign in_ready  = (state == ST_IDLE) || out_ready;
  assign out_valid = (state == ST_HOLD);

  always_comb begin
    dp_cmd.load = in_valid && in_ready;
    dp_cmd.op   = OP_PUSH;
    unique case (cmd)
      CMD_RX: begin
        if (status.waiting && status.has_reply) begin
          dp_cmd.op = OP_RESP;
        end else if (status.waiting && is_reply_code(rx_byte)) begin
          dp_cmd.op = OP_REPLY;
        end else begin
          dp_cmd.op = OP_PUSH;
        end
      end
      CMD_ARM:    dp_cmd.op = OP_ARM;
      CMD_PULL:   dp_cmd.op = OP_PULL;
      CMD_CANCEL: dp_cmd.op = OP_CANCEL;
      default:    dp_cmd.op = OP_PUSH;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (dp_cmd.load) state_next = ST_HOLD;
      ST_HOLD: if (out_ready && !dp_cmd.load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ps2rdf_dp.sv
// Datapath: ring FIFO storage and pointers, reply/response capture registers.
`default_nettype none
module ps2rdf_dp #(
  parameter int FIFO_DEPTH = ps2rdf_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ps2rdf_pkg::ps2rdf_cmd_t dp_cmd,
  input  wire logic [7:0]              rx_byte,
  input  wire logic                    expect_response,
  output ps2rdf_pkg::ps2rdf_status_t   status,
  output logic [7:0]                   pulled_byte,
  output logic                         pulled_valid,
  output logic [7:0]                   reply_code,
  output logic [7:0]                   response_byte,
  output logic                         busy_waiting,
  output logic                         fifo_empty,
  output logic                         fifo_full
);
  import ps2rdf_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr_inc;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic             full;
  logic             empty;
  logic             waiting;
  logic             expect_flag;
  logic [7:0]       reply;
  logic [7:0]       response;
  logic             pull_ok;
  logic             push_en;
  logic             pull_en;

  assign rd_ptr_inc = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign empty      = !full && (rd_ptr == wr_ptr);
  assign push_en    = dp_cmd.load && (dp_cmd.op == OP_PUSH);
  assign pull_en    = dp_cmd.load && (dp_cmd.op == OP_PULL);

  // Storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wr_ptr] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (pull_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      full        <= 1'b0;
      waiting     <= 1'b0;
      expect_flag <= 1'b0;
      reply       <= '0;
      response    <= '0;
      pull_ok     <= 1'b0;
    end else if (dp_cmd.load) begin
      pull_ok <= 1'b0;
      unique case (dp_cmd.op)
        OP_PUSH: begin
          wr_ptr <= wr_ptr_inc;
          if (full) begin
            rd_ptr <= wr_ptr_inc;
          end else if (wr_ptr_inc == rd_ptr) begin
            full <= 1'b1;
          end
        end
        OP_REPLY: begin
          reply    <= rx_byte;
          response <= '0;
          waiting  <= (rx_byte == CODE_ACK) && expect_flag;
        end
        OP_RESP: begin
          response <= rx_byte;
          waiting  <= 1'b0;
        end
        OP_ARM: begin
          waiting     <= 1'b1;
          expect_flag <= expect_response;
          reply       <= '0;
          response    <= '0;
        end
        OP_PULL: begin
          if (!empty) begin
            pull_ok <= 1'b1;
            rd_ptr  <= rd_ptr_inc;
            full    <= 1'b0;
          end
        end
        OP_CANCEL: waiting <= 1'b0;
        default: ;
      endcase
    end
  end

  assign status.waiting   = waiting;
  assign status.has_reply = (reply != '0);

  assign pulled_byte   = pull_ok ? rd_data : '0;
  assign pulled_valid  = pull_ok;
  assign reply_code    = reply;
  assign response_byte = response;
  assign busy_waiting  = waiting;
  assign fifo_empty    = empty;
  assign fifo_full     = full;

endmodule
`default_nettype wire

// File: rtl/ps2_receive_demux_fifo.sv
// Top level of the PS/2 receive demux with overwrite-oldest ring FIFO.
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   cmd[1:0], rx_byte[7:0], expect_response
//  out_ch   out  valid/ready   pulled_byte, pulled_valid, reply_code, response_byte,
//                              busy_waiting, fifo_empty, fifo_full
//
// One result per accepted item, shown in the cycle after the input transfer.
// Sustained rate is one item per clock while out_ch.ready stays high: all state
// is updated on the transfer, with the FIFO memory read port registered into the result.
// Output stall blocks input: in_ch.ready drops while a result waits untaken,
// and a new item is taken in the same cycle the pending result transfers.
// Synchronous reset clears pointers, flags and capture registers; the FIFO
// memory itself is not cleared (no clearing pass, ready right after reset).
`default_nettype none
`include "ps2_receive_demux_fifo_macros.svh"
module ps2_receive_demux_fifo #(
  parameter int FIFO_DEPTH = ps2rdf_pkg::FIFO_DEPTH_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  ps2rdf_in_if.sink     in_ch,
  ps2rdf_out_if.source  out_ch
);
  import ps2rdf_pkg::*;

  ps2rdf_cmd_t    dp_cmd;
  ps2rdf_status_t status;

  // Classifies each item and owns the result-register handshake
  ps2rdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cmd       (in_ch.cmd),
    .rx_byte   (in_ch.rx_byte),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .dp_cmd    (dp_cmd)
  );

  // FIFO, pointers and capture registers; outputs are post-step state
  ps2rdf_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .dp_cmd          (dp_cmd),
    .rx_byte         (in_ch.rx_byte),
    .expect_response (in_ch.expect_response),
    .status          (status),
    .pulled_byte     (out_ch.pulled_byte),
    .pulled_valid    (out_ch.pulled_valid),
    .reply_code      (out_ch.reply_code),
    .response_byte   (out_ch.response_byte),
    .busy_waiting    (out_ch.busy_waiting),
    .fifo_empty      (out_ch.fifo_empty),
    .fifo_full       (out_ch.fifo_full)
  );

  // Empty and full are exclusive
  `PS2RDF_ASSERT(a_empty_full_excl, clk, rst, !(out_ch.fifo_empty && out_ch.fifo_full))

  // A pending untaken result holds off the next input transfer
  `PS2RDF_ASSERT(a_stall_blocks_in, clk, rst, !(out_ch.valid && !out_ch.ready && in_ch.ready))

  // Arming starts a fresh wait with the stale reply dropped
  `PS2RDF_ASSERT_NEXT(a_arm_clears, clk, rst, in_ch.valid && in_ch.ready && in_ch.cmd == CMD_ARM, out_ch.valid && out_ch.busy_waiting && out_ch.reply_code == 8'h00)

  // Pull from a non-empty FIFO always returns a byte
  `PS2RDF_ASSERT_NEXT(a_pull_returns, clk, rst, in_ch.valid && in_ch.ready && in_ch.cmd == CMD_PULL && !out_ch.fifo_empty, out_ch.valid && out_ch.pulled_valid)

endmodule
`default_nettype wire

// File: tb/tb_ps2_receive_demux_fifo.sv
// Self-checking testbench for the PS/2 receive demux with overwrite-oldest FIFO.
`default_nettype none
module tb_ps2_receive_demux_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2rdf_pkg::*;

  localparam int DEPTH       = FIFO_DEPTH_DEF;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int MAX_IDLE    = 18;
  localparam int RANDOM_ITEMS = 300;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  // One result transfer as the block presents it.
  typedef struct packed {
    logic [7:0] pulled_byte;
    logic       pulled_valid;
    logic [7:0] reply_code;
    logic [7:0] response_byte;
    logic       busy_waiting;
    logic       fifo_empty;
    logic       fifo_full;
  } demux_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ps2rdf_in_if  in_ch ();
  ps2rdf_out_if out_ch ();

  ps2_receive_demux_fifo #(.FIFO_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow state of the block: ring store, pointers and the capture registers.
  // ---------------------------------------------------------------------------
  logic [7:0]       ring_copy [DEPTH];
  logic [PTR_W-1:0] rd_ptr = '0;
  logic [PTR_W-1:0] wr_ptr = '0;
  logic             ring_full = 1'b0;
  logic             wait_active = 1'b0;
  logic             want_response = 1'b0;
  logic [7:0]       reply_held = 8'h00;
  logic [7:0]       response_held = 8'h00;

  demux_result_t expected_results[$];

  int fails = 0;
  int items_in = 0;
  int results_checked = 0;
  int overwrites = 0;
  int replies_caught = 0;
  int responses_caught = 0;
  int cycles = 0;

  // Idle controls, flipped by the tests to get stretches with and without gaps.
  bit send_idle = 1'b1;
  bit take_idle = 1'b1;
  int take_hold = 0;   // nonzero: receiver holds ready low for a hold-off of this length

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic bit ring_is_empty();
    return !ring_full && (rd_ptr == wr_ptr);
  endfunction

  // Work out the result of one item and advance the shadow state.
  function automatic demux_result_t demux_step(input logic [1:0] c, input logic [7:0] b,
                                                input logic e);
    demux_result_t r;
    r = '0;
    case (c)
      CMD_RX: begin
        if (wait_active && reply_held != 8'h00) begin
          // ACK already in: this byte is the response, whatever its value
          response_held = b;
          wait_active = 1'b0;
          responses_caught++;
        end else if (wait_active &&
                     (b == CODE_ACK || b == CODE_RESEND || b == CODE_ECHO)) begin
          reply_held = b;
          response_held = 8'h00;
          wait_active = (b == CODE_ACK) && want_response;
          replies_caught++;
        end else begin
          // plain traffic; a full ring drops its oldest byte
          ring_copy[wr_ptr] = b;
          wr_ptr = ring_next(wr_ptr);
          if (ring_full) begin
            rd_ptr = wr_ptr;
            overwrites++;
          end else if (wr_ptr == rd_ptr) begin
            ring_full = 1'b1;
          end
        end
      end
      CMD_ARM: begin
        wait_active = 1'b1;
        want_response = e;
        reply_held = 8'h00;
        response_held = 8'h00;
      end
      CMD_PULL: begin
        if (!ring_is_empty()) begin
          r.pulled_byte = ring_copy[rd_ptr];
          r.pulled_valid = 1'b1;
          rd_ptr = ring_next(rd_ptr);
          ring_full = 1'b0;
        end
      end
      CMD_CANCEL: wait_active = 1'b0;
      default: ;
    endcase
    r.reply_code = reply_held;
    r.response_byte = response_held;
    r.busy_waiting = wait_active;
    r.fifo_empty = ring_is_empty();
    r.fifo_full = ring_full;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: results are checked first, then the input transfer of the same
  // edge is predicted. A result is registered and always trails its item, so
  // the order inside the edge cannot pair the wrong entries.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    demux_result_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing outstanding");
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("pulled_byte", want.pulled_byte, out_ch.pulled_byte);
          check_field("pulled_valid", 8'(want.pulled_valid), 8'(out_ch.pulled_valid));
          check_field("reply_code", want.reply_code, out_ch.reply_code);
          check_field("response_byte", want.response_byte, out_ch.response_byte);
          check_field("busy_waiting", 8'(want.busy_waiting), 8'(out_ch.busy_waiting));
          check_field("fifo_empty", 8'(want.fifo_empty), 8'(out_ch.fifo_empty));
          check_field("fifo_full", 8'(want.fifo_full), 8'(out_ch.fifo_full));
          results_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(demux_step(in_ch.cmd, in_ch.rx_byte,
                                              in_ch.expect_response));
        items_in++;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ps2_receive_demux_fifo failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. Per transfer it draws a stall; a requested hold-off
  // replaces the stall and is counted here, independent of the sender.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (take_hold > 0) begin
        stall = take_hold;
        take_hold = 0;
      end else begin
        stall = take_idle ? $urandom_range(MAX_IDLE, 0) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!(out_ch.valid && out_ch.ready) && take_hold == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. valid is left high after a transfer so back-to-back items never
  // see a low/high pair in one time step; the caller drops it when done.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] c, input logic [7:0] b, input logic e);
    int gap;
    gap = send_idle ? $urandom_range(MAX_IDLE, 0) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.rx_byte <= b;
    in_ch.expect_response <= e;
    do @(posedge clk);
    while (!in_ch.ready);
  endtask

  // Fields the block ignores still get random values so every bit moves.
  task automatic send_rx(input logic [7:0] b);
    send_item(CMD_RX, b, 1'($urandom));
  endtask

  task automatic send_ctrl(input logic [1:0] c, input logic e = 1'b0);
    send_item(c, 8'($urandom), (c == CMD_ARM) ? e : 1'($urandom));
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CODE_ACK || b == CODE_RESEND || b == CODE_ECHO);
    return b;
  endfunction

  function automatic logic [7:0] pick_reply();
    case ($urandom_range(3, 0))
      0:       return CODE_RESEND;
      1:       return CODE_ECHO;
      default: return CODE_ACK;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and each corner of the reply/response capture.
  task automatic test_directed();
    send_ctrl(CMD_PULL);              // pull with nothing stored
    send_ctrl(CMD_CANCEL);            // cancel with no wait active
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(CODE_ACK);                // reply code with no wait: plain traffic
    repeat (4) send_ctrl(CMD_PULL);   // last one hits an empty FIFO
    send_ctrl(CMD_ARM, 1'b1);
    send_rx(8'h55);                   // non-reply byte during the wait goes to FIFO
    send_rx(CODE_ACK);                // ACK, response still owed
    send_rx(CODE_RESEND);             // response byte may look like a code
    send_ctrl(CMD_ARM, 1'b0);
    send_rx(CODE_ACK);                // ACK ends wait when no response is owed
    send_ctrl(CMD_ARM, 1'b1);
    send_rx(CODE_RESEND);             // resend ends wait, no response
    send_ctrl(CMD_ARM, 1'b1);
    send_rx(CODE_ECHO);
    send_ctrl(CMD_ARM, 1'b1);
    send_ctrl(CMD_ARM, 1'b0);         // re-arm restarts, clears the stale reply
    send_rx(CODE_ACK);
    send_ctrl(CMD_ARM, 1'b1);
    send_rx(CODE_ACK);
    send_ctrl(CMD_CANCEL);            // ends the wait, captured values stay
    send_rx(8'h33);
    send_ctrl(CMD_PULL);
    send_ctrl(CMD_PULL);
    wait_drained();
  endtask

  // Fill past full so the oldest bytes get overwritten, then empty it out.
  task automatic test_overwrite();
    repeat (DEPTH + 4) send_rx(8'($urandom));
    repeat (DEPTH + 2) send_ctrl(CMD_PULL);
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering back to back, so the
  // result slot stays occupied and the input side must stall.
  task automatic test_backpressure();
    send_idle = 1'b0;
    take_hold = HOLD_CYCLES;
    repeat (24) begin
      if ($urandom_range(2, 0) == 0) send_ctrl(CMD_PULL);
      else send_rx(8'($urandom));
    end
    wait_drained();
    send_idle = 1'b1;
  endtask

  // Sender goes quiet until every result is back, then resumes at full rate.
  task automatic test_pause_resume();
    send_idle = 1'b0;
    take_idle = 1'b0;
    send_ctrl(CMD_ARM, 1'b1);
    send_rx(plain_byte());
    send_rx(CODE_ACK);
    wait_drained();
    send_rx(8'hA5);                   // response arrives after the pause
    repeat (4) send_ctrl(CMD_PULL);
    wait_drained();
    send_idle = 1'b1;
    take_idle = 1'b1;
  endtask

  // Complete command exchanges with random content around them, mixed with
  // plain traffic, pulls, broken exchanges and free noise.
  task automatic test_random();
    int start_count;
    int n;
    logic       want_resp;
    logic [7:0] code;
    start_count = items_in;
    while (items_in - start_count < RANDOM_ITEMS) begin
      // new idle stretches every so often, gaps on or off independently
      if ($urandom_range(15, 0) == 0) send_idle = ($urandom_range(2, 0) != 0);
      if ($urandom_range(15, 0) == 0) take_idle = ($urandom_range(2, 0) != 0);
      case ($urandom_range(9, 0))
        0, 1, 2, 3: begin
          want_resp = 1'($urandom);
          send_ctrl(CMD_ARM, want_resp);
          n = $urandom_range(2, 0);
          repeat (n) begin
            if ($urandom_range(1, 0) == 0) send_rx(plain_byte());
            else send_ctrl(CMD_PULL);
          end
          code = pick_reply();
          send_rx(code);
          if (want_resp && code == CODE_ACK) begin
            if ($urandom_range(9, 0) == 0) send_ctrl(CMD_CANCEL);   // timed out
            else if ($urandom_range(5, 0) == 0) send_rx(pick_reply());
            else send_rx(8'($urandom));
          end
        end
        4, 5, 6: begin
          n = $urandom_range(6, 1);
          repeat (n) begin
            if ($urandom_range(1, 0) == 0) send_rx(8'($urandom));
            else send_ctrl(CMD_PULL);
          end
        end
        7: begin
          n = $urandom_range(4, 1);
          repeat (n) send_ctrl(CMD_PULL);
        end
        8: send_item(2'($urandom), 8'($urandom), 1'($urandom));
        default: begin
          send_ctrl(CMD_ARM, 1'($urandom));
          if ($urandom_range(1, 0) == 0) send_ctrl(CMD_ARM, 1'($urandom));
          send_ctrl(CMD_CANCEL);
          send_rx(pick_reply());                 // late reply lands in the FIFO
        end
      endcase
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_RX;
    in_ch.rx_byte <= 8'h00;
    in_ch.expect_response <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_overwrite();
    test_backpressure();
    test_pause_resume();
    test_random();

    $display("Covered %0d input transfers, %0d results checked field by field;",
             items_in, results_checked);
    $display("%0d replies and %0d responses captured, %0d overwrites of a full FIFO.",
             replies_caught, responses_caught, overwrites);
    if (fails == 0) begin
      $display("tb_ps2_receive_demux_fifo passed");
    end else begin
      $display("tb_ps2_receive_demux_fifo failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
